// ===== rtl/bhs_pkg.sv =====
// Shared types and constants of the bilinear height-map sampler.
`default_nettype none

package bhs_pkg;

  // Width of the map dimension registers and of a cell coordinate
  localparam int DIM_W = 9;

  // Width of the clamped inverse tile size (saturates below 2^30)
  localparam int INV_W = 30;

  // Width of a linear cell address built from row * width + column
  localparam int BASE_W = 2 * DIM_W + 1;

  // Inverse tile size ceiling (tile size floor of 0.0001) and reset value
  localparam logic [31:0] INV_TILE_MAX   = 32'd655360000;
  localparam logic [31:0] INV_TILE_RESET = 32'd65536;

  // One in Q0.16, the sum of a weight and its complement
  localparam logic [16:0] WEIGHT_ONE = 17'h10000;

  // Rounding offset for Q16.48 down to Q16.16
  localparam logic [65:0] ROUND_HALF = 66'h0_0000_0000_8000_0000;

  // Configuration register indexes
  localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_INV_TILE   = 2'd2;

  // Item kinds carried in tuser
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // Clamped grid coordinate: integer cell and Q0.16 fraction
  typedef struct packed {
    logic [DIM_W-1:0] pos;
    logic [15:0]      frac;
  } coord_t;

endpackage

`default_nettype wire

// ===== rtl/bilinear_heightmap_sampler_core.sv =====
// Bilinear height-map sampler: cell writes and interpolated height queries.
// One word per cycle is taken while the result word is not stalled; the store is split
// into even and odd banks on the linear cell address, each with one write port and two
// read ports, so all four neighbours of a query are read in the same cycle.
// Reset clears the pipeline valid bits and the configuration registers (width and
// height 0, inverse tile size 1.0); the height store is not cleared.
`default_nettype none

module bilinear_heightmap_sampler_core
  import bhs_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  // Configuration write port
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [31:0]   cfg_data,
  // Input stream
  input  wire logic          s_tvalid,
  output logic               s_tready,
  // tdata: cell_index[15:0], cell_value[47:16], world_x[79:48], world_z[111:80]
  input  wire logic [111:0]  s_tdata,
  // tuser: operation[0]
  input  wire logic [0:0]    s_tuser,
  // Output stream
  output logic               m_tvalid,
  input  wire logic          m_tready,
  // tdata: sampled_height[31:0]
  output logic [31:0]        m_tdata
);

  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int BANK_DEPTH = (DEPTH + 1) / 2;
  localparam int BAW        = $clog2(BANK_DEPTH);

  // Configuration registers
  logic [DIM_W-1:0] map_width;
  logic [DIM_W-1:0] map_height;
  logic [INV_W-1:0] inv_tile;

  // Pipeline control
  logic adv;
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid, s7_valid;

  // Stage 1: scaled coordinates
  op_t                s1_op;
  logic               s1_live;
  logic               s1_in_range;
  logic [15:0]        s1_idx;
  logic [31:0]        s1_value;
  logic signed [62:0] s1_px;
  logic signed [62:0] s1_pz;

  // Stage 2: grid cells and weights
  op_t              s2_op;
  logic             s2_live;
  logic             s2_in_range;
  logic [15:0]      s2_idx;
  logic [31:0]      s2_value;
  logic [DIM_W-1:0] s2_x0;
  logic [DIM_W-1:0] s2_z0;
  logic [DIM_W-1:0] s2_z1;
  logic             s2_dx;
  logic [15:0]      s2_tx;
  logic [15:0]      s2_tz;

  // Stage 3: linear addresses
  op_t               s3_op;
  logic              s3_live;
  logic              s3_in_range;
  logic [15:0]       s3_idx;
  logic [31:0]       s3_value;
  logic [BASE_W-1:0] s3_base0;
  logic [BASE_W-1:0] s3_base1;
  logic              s3_dx;
  logic [15:0]       s3_tx;
  logic [15:0]       s3_tz;

  // Stage 4: store read data
  logic        s4_live;
  logic        s4_odd0;
  logic        s4_odd1;
  logic        s4_dx;
  logic [15:0] s4_tx;
  logic [15:0] s4_tz;
  logic [31:0] rd_even0, rd_even1, rd_odd0, rd_odd1;

  // Stage 5: row weight products
  logic               s5_live;
  logic [15:0]        s5_tz;
  logic signed [48:0] s5_p00, s5_p10, s5_p01, s5_p11;

  // Stage 6: row blends
  logic               s6_live;
  logic [15:0]        s6_tz;
  logic signed [48:0] s6_h0, s6_h1;

  // Stage 7: column weight products
  logic               s7_live;
  logic signed [65:0] s7_q0, s7_q1;

  // Height store, banked on the low address bit
  logic [31:0] bank_even [BANK_DEPTH];
  logic [31:0] bank_odd  [BANK_DEPTH];

  // Combinational helpers
  logic             map_zero;
  logic [DIM_W-1:0] width_m1, height_m1;
  coord_t           cx, cz;
  logic [2*DIM_W-1:0] row0, row1;
  logic [BAW-1:0]   wr_entry;
  logic [BAW-1:0]   ev_addr0, ev_addr1, od_addr0, od_addr1;
  logic             wr_even, wr_odd;
  logic [31:0]      c00, c10, c01, c11;
  logic [16:0]      wxn, wzn;
  logic [65:0]      col_sum;

  // Clamp a scaled coordinate to the grid and split it into cell and fraction
  function automatic coord_t grid_coord(input logic signed [62:0] p,
                                        input logic [DIM_W-1:0] dim_m1);
    logic signed [63:0] g;
    logic signed [63:0] off;
    logic signed [63:0] hi;
    coord_t             c;
    off = $signed({24'd0, dim_m1, 31'd0});
    hi  = $signed({23'd0, dim_m1, 32'd0});
    g   = 64'(p) + off;
    if (g[63]) begin
      g = '0;
    end else if (g > hi) begin
      g = hi;
    end
    c.pos  = g[32+DIM_W-1:32];
    c.frac = g[31:16];
    return c;
  endfunction

  // Configuration writes; saturate the inverse tile size on the way in
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= '0;
      map_height <= '0;
      inv_tile   <= INV_W'(INV_TILE_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAP_WIDTH:  map_width  <= cfg_data[DIM_W-1:0];
        REG_MAP_HEIGHT: map_height <= cfg_data[DIM_W-1:0];
        REG_INV_TILE: begin
          if (cfg_data > INV_TILE_MAX) begin
            inv_tile <= INV_W'(INV_TILE_MAX);
          end else begin
            inv_tile <= cfg_data[INV_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline unless the result word is stalled
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s_tvalid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
      s7_valid <= s6_valid;
      m_tvalid <= s7_valid;
    end
  end

  // An empty or oversized map answers zero
  assign map_zero = (map_width == '0) || (map_height == '0)
                 || (32'(map_width) > 32'(MAX_WIDTH))
                 || (32'(map_height) > 32'(MAX_HEIGHT));

  // Stage 1: scale world coordinates by the inverse tile size
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op       <= op_t'(s_tuser[0]);
      s1_live     <= (op_t'(s_tuser[0]) == OP_QUERY) && !map_zero;
      s1_in_range <= 32'(s_tdata[15:0]) < 32'(DEPTH);
      s1_idx      <= s_tdata[15:0];
      s1_value    <= s_tdata[47:16];
      s1_px       <= $signed(s_tdata[79:48]) * $signed({1'b0, inv_tile});
      s1_pz       <= $signed(s_tdata[111:80]) * $signed({1'b0, inv_tile});
    end
  end

  // Stage 2: offset, clamp, split into cell and weight
  assign width_m1  = map_width - DIM_W'(1);
  assign height_m1 = map_height - DIM_W'(1);
  assign cx        = grid_coord(s1_px, width_m1);
  assign cz        = grid_coord(s1_pz, height_m1);

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_op       <= s1_op;
      s2_live     <= s1_live;
      s2_in_range <= s1_in_range;
      s2_idx      <= s1_idx;
      s2_value    <= s1_value;
      s2_x0       <= cx.pos;
      s2_z0       <= cz.pos;
      s2_z1       <= (cz.pos != height_m1) ? cz.pos + DIM_W'(1) : cz.pos;
      s2_dx       <= cx.pos != width_m1;
      s2_tx       <= cx.frac;
      s2_tz       <= cz.frac;
    end
  end

  // Stage 3: linear addresses of the two rows
  assign row0 = s2_z0 * map_width;
  assign row1 = s2_z1 * map_width;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_op       <= s2_op;
      s3_live     <= s2_live;
      s3_in_range <= s2_in_range;
      s3_idx      <= s2_idx;
      s3_value    <= s2_value;
      s3_base0    <= BASE_W'(row0) + BASE_W'(s2_x0);
      s3_base1    <= BASE_W'(row1) + BASE_W'(s2_x0);
      s3_dx       <= s2_dx;
      s3_tx       <= s2_tx;
      s3_tz       <= s2_tz;
    end
  end

  // Bank addresses: the column pair of a row straddles the two banks
  assign od_addr0 = BAW'(s3_base0 >> 1);
  assign od_addr1 = BAW'(s3_base1 >> 1);
  assign ev_addr0 = BAW'((s3_base0 >> 1) + BASE_W'(s3_base0[0] & s3_dx));
  assign ev_addr1 = BAW'((s3_base1 >> 1) + BASE_W'(s3_base1[0] & s3_dx));

  // Writes issue in the same stage as reads, so program order is kept
  assign wr_entry = BAW'(s3_idx >> 1);
  assign wr_even  = adv && s3_valid && (s3_op == OP_WRITE) && s3_in_range && !s3_idx[0];
  assign wr_odd   = adv && s3_valid && (s3_op == OP_WRITE) && s3_in_range && s3_idx[0];

  // Even bank: one write, two registered reads
  always_ff @(posedge clk) begin
    if (wr_even) begin
      bank_even[wr_entry] <= s3_value;
    end
    if (adv) begin
      rd_even0 <= bank_even[ev_addr0];
      rd_even1 <= bank_even[ev_addr1];
    end
  end

  // Odd bank: one write, two registered reads
  always_ff @(posedge clk) begin
    if (wr_odd) begin
      bank_odd[wr_entry] <= s3_value;
    end
    if (adv) begin
      rd_odd0 <= bank_odd[od_addr0];
      rd_odd1 <= bank_odd[od_addr1];
    end
  end

  // Stage 4: hold the routing of the read data alongside it
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_live <= s3_live;
      s4_odd0 <= s3_base0[0];
      s4_odd1 <= s3_base1[0];
      s4_dx   <= s3_dx;
      s4_tx   <= s3_tx;
      s4_tz   <= s3_tz;
    end
  end

  // Stage 5: pick the four neighbours and weight them by column
  assign c00 = s4_odd0 ? rd_odd0 : rd_even0;
  assign c10 = s4_dx ? (s4_odd0 ? rd_even0 : rd_odd0) : c00;
  assign c01 = s4_odd1 ? rd_odd1 : rd_even1;
  assign c11 = s4_dx ? (s4_odd1 ? rd_even1 : rd_odd1) : c01;
  assign wxn = WEIGHT_ONE - {1'b0, s4_tx};

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_live <= s4_live;
      s5_tz   <= s4_tz;
      s5_p00  <= $signed(c00) * $signed({1'b0, wxn});
      s5_p10  <= $signed(c10) * $signed({2'b00, s4_tx});
      s5_p01  <= $signed(c01) * $signed({1'b0, wxn});
      s5_p11  <= $signed(c11) * $signed({2'b00, s4_tx});
    end
  end

  // Stage 6: row blends in Q16.32
  always_ff @(posedge clk) begin
    if (adv) begin
      s6_live <= s5_live;
      s6_tz   <= s5_tz;
      s6_h0   <= s5_p00 + s5_p10;
      s6_h1   <= s5_p01 + s5_p11;
    end
  end

  // Stage 7: weight the rows
  assign wzn = WEIGHT_ONE - {1'b0, s6_tz};

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_live <= s6_live;
      s7_q0   <= s6_h0 * $signed({1'b0, wzn});
      s7_q1   <= s6_h1 * $signed({2'b00, s6_tz});
    end
  end

  // Stage 8: column blend, round half up to Q16.16, zero the result of non-query words
  assign col_sum = 66'(s7_q0) + 66'(s7_q1) + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= s7_live ? col_sum[63:32] : '0;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/bhs_tb_pkg.sv =====
// Scoreboard class for the height-map sampler: own grid copy and height predictor.
`timescale 1ns / 1ps

package bhs_tb_pkg;
  import bhs_pkg::*;

  // Grid limits of the block as built (default parameters)
  localparam int MAP_COLS_MAX = 256;
  localparam int MAP_ROWS_MAX = 256;
  localparam int STORE_WORDS  = MAP_COLS_MAX * MAP_ROWS_MAX;

  // Keep the log short when a run goes badly wrong
  localparam int REPORT_LINES_MAX = 100;

  // Wide enough for every blend product without overflow
  typedef logic signed [79:0] wide_t;

  class height_scoreboard;
    logic [31:0] height_mem [STORE_WORDS];
    bit          written    [STORE_WORDS];
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic [31:0] inv_reg;
    logic [31:0] expected_heights [$];
    int          errors;
    int          results_seen;

    function new();
      width_reg    = '0;
      height_reg   = '0;
      inv_reg      = INV_TILE_RESET;
      errors       = 0;
      results_seen = 0;
    endfunction

    // Mirror one configuration register write
    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_MAP_WIDTH:  width_reg  = data[8:0];
        REG_MAP_HEIGHT: height_reg = data[8:0];
        REG_INV_TILE:   inv_reg    = data;
        default: ;
      endcase
    endfunction

    // A grid that the store can hold and that has at least one cell
    function bit map_ready();
      return width_reg != 0 && height_reg != 0 &&
             width_reg <= MAP_COLS_MAX && height_reg <= MAP_ROWS_MAX;
    endfunction

    function int pending();
      return expected_heights.size();
    endfunction

    // Scale, centre and clamp one world coordinate; split into cell and Q0.16 weight
    function void grid_axis(logic signed [31:0] world, int dim, output int pos,
                            output int frac);
      longint inv_sat;
      longint g;
      longint top;
      inv_sat = (inv_reg > INV_TILE_MAX) ? longint'(INV_TILE_MAX) : longint'(inv_reg);
      g   = longint'(world) * inv_sat + (longint'(dim - 1) <<< 31);
      top = longint'(dim - 1) <<< 32;
      if (g < 0) g = 0;
      if (g > top) g = top;
      pos  = int'(g >>> 32);
      frac = int'(g[31:16]);
    endfunction

    // Linear addresses of the four neighbours, far index clamped at the edge
    function void locate(logic signed [31:0] wx, logic signed [31:0] wz,
                         output int cells [4], output int tx, output int tz);
      int x0, x1, z0, z1;
      int w, h;
      w = int'(width_reg);
      h = int'(height_reg);
      grid_axis(wx, w, x0, tx);
      grid_axis(wz, h, z0, tz);
      x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
      z1 = (z0 + 1 < h) ? z0 + 1 : h - 1;
      cells[0] = z0 * w + x0;
      cells[1] = z0 * w + x1;
      cells[2] = z1 * w + x0;
      cells[3] = z1 * w + x1;
    endfunction

    function wide_t stored_height(int idx);
      if (idx >= STORE_WORDS) return '0;
      return wide_t'($signed(height_mem[idx]));
    endfunction

    // Bilinear blend in Q16.48, rounded half up to Q16.16
    function logic [31:0] sample_height(logic signed [31:0] wx, logic signed [31:0] wz);
      int    cells [4];
      int    tx, tz;
      wide_t one_w;
      wide_t near_row, far_row, blend;
      if (!map_ready()) return '0;
      locate(wx, wz, cells, tx, tz);
      one_w    = wide_t'(WEIGHT_ONE);
      near_row = stored_height(cells[0]) * (one_w - tx) + stored_height(cells[1]) * tx;
      far_row  = stored_height(cells[2]) * (one_w - tx) + stored_height(cells[3]) * tx;
      blend    = near_row * (one_w - tz) + far_row * tz;
      blend    = (blend + wide_t'(ROUND_HALF)) >>> 32;
      return blend[31:0];
    endfunction

    // Note an accepted input word: store a cell or predict a height
    function void note_word(op_t op, logic [111:0] data);
      logic [15:0] idx;
      idx = data[15:0];
      if (op == OP_WRITE) begin
        if (int'(idx) < STORE_WORDS) begin
          height_mem[idx] = data[47:16];
          written[idx]    = 1'b1;
        end
        expected_heights.insert(expected_heights.size(), '0);
      end else begin
        expected_heights.insert(expected_heights.size(),
                                sample_height(data[79:48], data[111:80]));
      end
    endfunction

    task report(string msg);
      if (errors < REPORT_LINES_MAX) $display("[%0t] ERROR: %s", $realtime, msg);
      errors++;
    endtask

    // Check one accepted result word against the oldest prediction
    task check_height(logic [31:0] got);
      logic [31:0] want;
      results_seen++;
      if (expected_heights.size() == 0) begin
        report($sformatf("result %0d: unexpected word %08h", results_seen, got));
      end else begin
        want = expected_heights.pop_front();
        if (got !== want)
          report($sformatf("result %0d: sampled_height %08h, want %08h",
                           results_seen, got, want));
      end
    endtask
  endclass

endpackage

// ===== tb/sv/tb_bilinear_heightmap_sampler_core.sv =====
// Testbench top: drives cell writes and height queries, checks every result word.
`timescale 1ns / 1ps

module tb_bilinear_heightmap_sampler_core;
  import bhs_pkg::*;
  import bhs_tb_pkg::*;

  localparam int PIPE_LATENCY   = 8;
  localparam int RANDOM_ITEMS   = 1700;
  localparam int WATCHDOG_LIMIT = 5000;

  localparam logic signed [31:0] WORLD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] WORLD_MIN = 32'sh8000_0000;

  typedef enum int {
    READY_ALWAYS,
    READY_HALF,
    READY_SPARSE,
    READY_PERIODIC
  } ready_mode_t;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          cfg_we    = 1'b0;
  logic [1:0]    cfg_index = REG_MAP_WIDTH;
  logic [31:0]   cfg_data  = '0;
  logic          s_tvalid  = 1'b0;
  logic          s_tready;
  // tdata: cell_index[15:0], cell_value[47:16], world_x[79:48], world_z[111:80]
  logic [111:0]  s_tdata   = '0;
  // tuser: operation[0]
  logic [0:0]    s_tuser   = OP_WRITE;
  logic          m_tvalid;
  logic          m_tready  = 1'b0;
  // tdata: sampled_height[31:0]
  logic [31:0]   m_tdata;

  height_scoreboard sb;

  int          burst_left  = 0;
  bit          steady      = 1'b0;
  int          items_sent  = 0;
  int          idle_cycles = 0;
  ready_mode_t ready_mode  = READY_ALWAYS;
  int          mode_left   = 0;
  int          ready_tick  = 0;

  bilinear_heightmap_sampler_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Check result words and stall the master side on a changing pattern
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_height(m_tdata);
    ready_tick <= ready_tick + 1;
    if (mode_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      mode_left  <= $urandom_range(20, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      READY_ALWAYS:   m_tready <= 1'b1;
      READY_HALF:     m_tready <= $urandom_range(0, 1);
      READY_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
      default:        m_tready <= (ready_tick % 7) < 4;
    endcase
  end

  // Count cycles in which no word moves on either side and no configuration write happens
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("[%0t] watchdog: no word moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Offer one word, in bursts with random gaps, and hold it until accepted
  task automatic send_word(op_t op, logic [111:0] data);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_word(op, data);
    items_sent++;
  endtask

  task automatic write_word(logic [15:0] idx, logic [31:0] val);
    send_word(OP_WRITE, {32'($urandom), 32'($urandom), val, idx});
  endtask

  // Query a position; first write any neighbour cell that holds no sample yet
  task automatic query_word(logic signed [31:0] wx, logic signed [31:0] wz);
    int cells [4];
    int tx, tz;
    if (sb.map_ready()) begin
      sb.locate(wx, wz, cells, tx, tz);
      for (int i = 0; i < 4; i++)
        if (!sb.written[cells[i]]) write_word(16'(cells[i]), $urandom);
    end
    send_word(OP_QUERY, {wz, wx, 32'($urandom), 16'($urandom)});
  endtask

  // Drop valid and hold until every predicted height has come back
  task automatic drain();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // Reconfigure the grid while the block is idle
  task automatic set_map(int w, int h, logic [31:0] inv);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAP_WIDTH;
    cfg_data  <= 32'(w);
    @(posedge clk);
    sb.set_reg(REG_MAP_WIDTH, 32'(w));
    cfg_index <= REG_MAP_HEIGHT;
    cfg_data  <= 32'(h);
    @(posedge clk);
    sb.set_reg(REG_MAP_HEIGHT, 32'(h));
    cfg_index <= REG_INV_TILE;
    cfg_data  <= inv;
    @(posedge clk);
    sb.set_reg(REG_INV_TILE, inv);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // World coordinate: mostly near the grid, some extremes, some anywhere
  function automatic logic signed [31:0] rand_world();
    logic signed [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 9))
      0: return raw;
      1: begin
        case ($urandom_range(0, 4))
          0: return WORLD_MAX;
          1: return WORLD_MIN;
          2: return 32'sd0;
          3: return 32'sd1;
          default: return -32'sd1;
        endcase
      end
      default: return raw >>> (31 - $urandom_range(10, 26));
    endcase
  endfunction

  function automatic logic [31:0] rand_inv();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return INV_TILE_MAX;
      3: return INV_TILE_MAX + 1;
      4: return $urandom;
      5: return 32'd1;
      default: return $urandom_range(16384, 262144);
    endcase
  endfunction

  initial begin
    int w, h, n, cells_in_map;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty map straight after reset, then extreme cell samples
    query_word(WORLD_MAX, WORLD_MIN);
    write_word(16'hFFFF, 32'h8000_0000);
    write_word(16'h0000, 32'h7FFF_FFFF);

    // Small grid at unit tile: centre, both far corners, fractional weights
    set_map(2, 2, INV_TILE_RESET);
    write_word(16'd1, 32'h8000_0000);
    write_word(16'd2, 32'hFFFF_FFFF);
    write_word(16'd3, 32'h0001_8000);
    query_word(32'sd0, 32'sd0);
    query_word(WORLD_MAX, WORLD_MAX);
    query_word(WORLD_MIN, WORLD_MIN);
    query_word(32'sh0000_8000, 32'shFFFF_C000);

    // Zero inverse tile lands on the centre; huge one saturates
    set_map(2, 2, 32'h0);
    query_word(32'sh1234_5678, 32'sh8765_4321);
    set_map(2, 2, 32'hFFFF_FFFF);
    query_word(32'sd1, -32'sd1);

    // Single cell, oversized grids, then the full grid
    set_map(1, 1, INV_TILE_RESET);
    query_word(32'sh0001_0000, 32'sd0);
    set_map(257, 2, INV_TILE_RESET);
    query_word(32'sd0, 32'sd0);
    set_map(2, 511, INV_TILE_RESET);
    query_word(32'sd0, 32'sd0);
    set_map(256, 256, INV_TILE_RESET);
    query_word(32'sd0, 32'sd0);
    query_word(WORLD_MAX, WORLD_MIN);

    // Random phases, each under a setting of its own
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0: begin w = 0; h = $urandom_range(1, 16); end
        1: begin w = $urandom_range(1, 16); h = 0; end
        2: begin w = 256; h = 256; end
        3: begin w = $urandom_range(257, 511); h = $urandom_range(1, 16); end
        4: begin w = $urandom_range(1, 16); h = $urandom_range(257, 511); end
        5: begin w = 1; h = 1; end
        6: begin w = 256; h = $urandom_range(1, 4); end
        7: begin w = $urandom_range(1, 4); h = 256; end
        default: begin w = $urandom_range(1, 16); h = $urandom_range(1, 16); end
      endcase
      set_map(w, h, rand_inv());
      steady = ($urandom_range(0, 3) == 0);
      cells_in_map = w * h;

      // Fill small grids in order before querying them
      if (sb.map_ready() && cells_in_map <= 64 && $urandom_range(0, 1))
        for (int i = 0; i < cells_in_map; i++) write_word(16'(i), $urandom);

      n = $urandom_range(40, 120);
      for (int i = 0; i < n; i++) begin
        if (i == n / 2 && $urandom_range(0, 3) == 0) drain();
        case ($urandom_range(0, 9))
          0, 1: begin
            if (sb.map_ready())
              write_word(16'($urandom_range(0, cells_in_map - 1)), $urandom);
            else
              write_word(16'($urandom), $urandom);
          end
          2: write_word(16'($urandom), $urandom);
          default: query_word(rand_world(), rand_world());
        endcase
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
